/* hdl/mtsd_pkg.sv */
// Shared types and constants for the mask table stream decryptor.
// No dependencies; used by mtsd_front, mtsd_back and the top module.
`default_nettype none

package mtsd_pkg;

  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_DATA    = 1'b1;

  localparam logic [7:0] CFG_SEED_FIRST  = 8'd0;
  localparam logic [7:0] CFG_SEED_SECOND = 8'd1;

  localparam logic [31:0] KEY_XOR = 32'hF765_4321;
  localparam int unsigned ROT_K0  = 25;
  localparam int unsigned ROT_K1  = 29;
  localparam int unsigned STEP_A  = 7;
  localparam int unsigned STEP_C  = 3;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/mtsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mtsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/mtsd_fifo.sv */
// Small register-based queue of words, first in first out.
// No dependencies.
`default_nettype none

module mtsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/mtsd_front.sv */
// Input side: accepts words, drops data words seen before any restart,
// and queues the rest for the back end. Uses mtsd_pkg and mtsd_fifo.
`default_nettype none

module mtsd_front #(
  parameter int unsigned CMD_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic          mode_i,
  input  wire logic [7:0]    byte_in_i,
  output mtsd_pkg::cmd_t     cmd_o,
  output logic               cmd_empty_o,
  input  wire logic          cmd_pop_i
);

  logic           built_q, built_d;
  logic           accept, enq;
  mtsd_pkg::cmd_t cmd_in;
  logic [8:0]     cmd_raw;

  assign accept = push_i && !full_o;
  assign enq    = accept && ((mode_i == mtsd_pkg::MODE_RESTART) || built_q);
  assign cmd_in = '{mode: mode_i, data: byte_in_i};
  assign cmd_o  = mtsd_pkg::cmd_t'(cmd_raw);

  always_comb begin
    built_d = built_q;
    if (accept && (mode_i == mtsd_pkg::MODE_RESTART)) begin
      built_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q <= 1'b0;
    end else begin
      built_q <= built_d;
    end
  end

  mtsd_fifo #(
    .WIDTH (9),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty_o)
  );

endmodule

`default_nettype wire

/* hdl/mtsd_back.sv */
// Back end: mask table build sequencer and byte decrypt pipeline.
// Uses mtsd_pkg and three mtsd_ram copies of the table (one per read).
`default_nettype none

module mtsd_back #(
  parameter int unsigned MASK_DEPTH = 4096
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mtsd_pkg::cmd_t cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  input  wire logic [31:0]    seed_first_i,
  input  wire logic [31:0]    seed_second_i,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output logic      [7:0]     res_data_o
);

  localparam int unsigned IW   = $clog2(MASK_DEPTH);
  localparam int unsigned ROWS = (MASK_DEPTH + 3) / 4;
  localparam int unsigned RW   = $clog2(ROWS);
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(MASK_DEPTH);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_BUILD = 1'b1;

  logic          state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [31:0]   k0_q, k0_d, k1_q, k1_d;
  logic [IW-1:0] a_q, a_d, c_q, c_d, a1;
  logic [IW:0]   a_sum, c_sum;
  logic          s1_q, s1_d;
  logic [1:0]    sa_q, sa1_q, sc_q;
  logic [7:0]    byte_q;
  logic          s1_free, is_restart, rd_en, wr_en;
  logic [31:0]   s1x, rot0, rot1, row_data;
  logic [31:0]   rd_a, rd_a1, rd_c;
  logic [7:0]    m_a, m_a1, m_c;

  function automatic logic [7:0] pick(input logic [31:0] w, input logic [1:0] s);
    logic [7:0] r;
    case (s)
      2'd0:    r = w[7:0];
      2'd1:    r = w[15:8];
      2'd2:    r = w[23:16];
      default: r = w[31:24];
    endcase
    return r;
  endfunction

  assign s1_free    = !s1_q || !res_full_i;
  assign is_restart = (cmd_i.mode == mtsd_pkg::MODE_RESTART);
  assign cmd_pop_o  = (state_q == ST_RUN) && !cmd_empty_i && (is_restart || s1_free);
  assign rd_en      = cmd_pop_o && !is_restart;
  assign wr_en      = (state_q == ST_BUILD);

  // one mask round: four table bytes per cycle
  assign s1x  = k1_q ^ mtsd_pkg::KEY_XOR;
  assign rot0 = (s1x << mtsd_pkg::ROT_K0) | (s1x >> (32 - mtsd_pkg::ROT_K0));
  assign rot1 = (k0_q << mtsd_pkg::ROT_K1) | (k0_q >> (32 - mtsd_pkg::ROT_K1));
  assign row_data = {rot1[31:24], k0_q[26:19], k0_q[18:11], k0_q[10:3]};

  assign a1    = (a_q == IW'(MASK_DEPTH - 1)) ? '0 : a_q + 1'b1;
  assign a_sum = {1'b0, a_q} + (IW + 1)'(mtsd_pkg::STEP_A);
  assign c_sum = {1'b0, c_q} + (IW + 1)'(mtsd_pkg::STEP_C);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    k0_d    = k0_q;
    k1_d    = k1_q;
    a_d     = a_q;
    c_d     = c_q;
    case (state_q)
      ST_RUN: begin
        if (cmd_pop_o && is_restart) begin
          state_d = ST_BUILD;
          row_d   = '0;
          k0_d    = seed_first_i;
          k1_d    = seed_second_i;
          a_d     = '0;
          c_d     = '0;
        end else if (rd_en) begin
          a_d = (a_sum >= DEPTH_W) ? IW'(a_sum - DEPTH_W) : IW'(a_sum);
          c_d = (c_sum >= DEPTH_W) ? IW'(c_sum - DEPTH_W) : IW'(c_sum);
        end
      end
      ST_BUILD: begin
        k0_d  = rot0 + k0_q;
        k1_d  = rot1;
        row_d = row_q + 1'b1;
        if (row_q == RW'(ROWS - 1)) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    s1_d = s1_q;
    if (rd_en) begin
      s1_d = 1'b1;
    end else if (res_push_o) begin
      s1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      row_q   <= '0;
      a_q     <= '0;
      c_q     <= '0;
      s1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      a_q     <= a_d;
      c_q     <= c_d;
      s1_q    <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k0_q <= k0_d;
    k1_q <= k1_d;
    if (rd_en) begin
      sa_q   <= a_q[1:0];
      sa1_q  <= a1[1:0];
      sc_q   <= c_q[1:0];
      byte_q <= cmd_i.data;
    end
  end

  mtsd_ram #(.WIDTH(32), .DEPTH(ROWS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (row_q),
    .wdata_i (row_data),
    .re_i    (rd_en),
    .raddr_i (a_q[2 +: RW]),
    .rdata_o (rd_a)
  );

  mtsd_ram #(.WIDTH(32), .DEPTH(ROWS)) u_ram_a1 (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (row_q),
    .wdata_i (row_data),
    .re_i    (rd_en),
    .raddr_i (a1[2 +: RW]),
    .rdata_o (rd_a1)
  );

  mtsd_ram #(.WIDTH(32), .DEPTH(ROWS)) u_ram_c (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (row_q),
    .wdata_i (row_data),
    .re_i    (rd_en),
    .raddr_i (c_q[2 +: RW]),
    .rdata_o (rd_c)
  );

  assign m_a  = pick(rd_a, sa_q);
  assign m_a1 = pick(rd_a1, sa1_q);
  assign m_c  = pick(rd_c, sc_q);

  assign res_push_o = s1_q && !res_full_i;
  assign res_data_o = ((byte_q - m_a1) ^ m_c) + m_a;

endmodule

`default_nettype wire

/* hdl/mask_table_stream_decrypt.sv */
// Byte stream decryptor driven by a mask table built from two seed words.
// Outside a table rebuild, the byte stream runs at one byte per clock while
// the output queue has room. A restart word holds the back end while it
// rebuilds the table: the restart is taken, then one table row of four mask
// bytes per cycle is written into three RAM copies, one for each table read
// a data byte needs. Data words pushed before the first restart are dropped.
// Seeds are sampled when the restart reaches the back end; write them only
// while the block is idle.
// Uses mtsd_pkg, mtsd_front, mtsd_back and mtsd_fifo.
`default_nettype none

module mask_table_stream_decrypt #(
  parameter int unsigned MASK_DEPTH = 4096,
  parameter int unsigned CMD_DEPTH  = 2,
  parameter int unsigned OUT_DEPTH  = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        mode_i,
  input  wire logic [7:0]  byte_in_i,
  output logic             empty,
  input  wire logic        pop,
  output logic      [7:0]  byte_out_o
);

  logic [31:0]    seed_first_q, seed_first_d, seed_second_q, seed_second_d;
  mtsd_pkg::cmd_t cmd;
  logic           cmd_empty, cmd_pop;
  logic           res_full, res_push;
  logic [7:0]     res_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    seed_first_d  = seed_first_q;
    seed_second_d = seed_second_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mtsd_pkg::CFG_SEED_FIRST:  seed_first_d  = cfg_data_i;
        mtsd_pkg::CFG_SEED_SECOND: seed_second_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_first_q  <= '0;
      seed_second_q <= '0;
    end else begin
      seed_first_q  <= seed_first_d;
      seed_second_q <= seed_second_d;
    end
  end

  mtsd_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .mode_i      (mode_i),
    .byte_in_i   (byte_in_i),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  mtsd_back #(
    .MASK_DEPTH (MASK_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .seed_first_i  (seed_first_q),
    .seed_second_i (seed_second_q),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_data_o    (res_data)
  );

  mtsd_fifo #(
    .WIDTH (8),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (byte_out_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire
